>>> rtl/segment_tree_range_sum_core_defines.svh
// ---------------------------------------------------------------------------
// segment_tree_range_sum_core_defines.svh
// Assertion macros used by the stsr_chk port checker.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_TREE_RANGE_SUM_CORE_DEFINES_SVH
`define SEGMENT_TREE_RANGE_SUM_CORE_DEFINES_SVH

// clocked assertion, off while reset is asserted
`define STSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also covers the reset cycles
`define STSR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/stsr_pkg.sv
// ---------------------------------------------------------------------------
// stsr_pkg
// Shared widths, codes and defaults of the segment tree range sum core.
// ---------------------------------------------------------------------------
package stsr_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;

  localparam int INDEX_W  = 10;
  localparam int VALUE_W  = 32;
  localparam int LENGTH_W = 11;

  localparam logic [LENGTH_W-1:0] LENGTH_RESET = 11'd1024;

  localparam logic MODE_SET   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

endpackage

>>> rtl/stsr_ram.sv
// ---------------------------------------------------------------------------
// stsr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module stsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/segment_tree_range_sum_core.sv
// ---------------------------------------------------------------------------
// segment_tree_range_sum_core
// Segment tree of wrapping 32-bit partial sums with point set and range query.
// ---------------------------------------------------------------------------
// Usage: after reset the core clears its tree memory, one node a cycle, and
// holds busy high until the clear is done; cfg writes are taken during that
// time. An item is taken when start is high and busy is low. A set walks the
// tree bottom-up through one memory read and one write per level; a set whose
// index is outside the array is ignored and the core stays idle. A query
// reads at most two nodes per level through the single read port and then
// returns the sum. Its result is strobed on out_valid for exactly one cycle,
// the cycle in which busy drops; the receiver cannot stall it, so sample
// out_range_sum whenever out_valid is high.
// ---------------------------------------------------------------------------
module segment_tree_range_sum_core #(
  parameter int MAX_ELEMENTS = stsr_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_mode,
  input  logic        [stsr_pkg::INDEX_W-1:0]  in_low_index,
  input  logic        [stsr_pkg::INDEX_W-1:0]  in_high_index,
  input  logic signed [stsr_pkg::VALUE_W-1:0]  in_new_value,
  output logic                                 out_valid,
  output logic signed [stsr_pkg::VALUE_W-1:0]  out_range_sum,
  input  logic                                 cfg_wr_en,
  input  logic        [stsr_pkg::LENGTH_W-1:0] cfg_wr_data
);

  import stsr_pkg::*;

  localparam int LVL   = $clog2(MAX_ELEMENTS);
  localparam int AW    = LVL + 1;
  localparam int RW    = LVL + 2;
  localparam int DEPTH = 2 * MAX_ELEMENTS;

  typedef enum logic [1:0] {ST_CLR, ST_IDLE, ST_UPD, ST_QRY} state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [AW-1:0]       node_r, node_nxt;
  logic [VALUE_W-1:0]  cur_r, cur_nxt;
  logic [RW-1:0]       l_r, l_nxt;
  logic [RW-1:0]       r_r, r_nxt;
  logic [VALUE_W-1:0]  acc_r, acc_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_sum_r, out_sum_nxt;
  logic [LENGTH_W-1:0] len_r;

  logic                ram_wr_en, ram_rd_en;
  logic [AW-1:0]       ram_wr_addr, ram_rd_addr;
  logic [VALUE_W-1:0]  ram_wr_data, ram_rd_data;

  logic [31:0]         n32, lo32, hi32, hic32;
  logic                set_ok, qry_ok;
  logic [AW-1:0]       leaf, parent;
  logic [RW-1:0]       l1, r1;
  logic [VALUE_W-1:0]  acc_add;

  stsr_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    n32    = (32'(len_r) > 32'(MAX_ELEMENTS)) ? 32'(MAX_ELEMENTS) : 32'(len_r);
    lo32   = 32'(in_low_index);
    hi32   = 32'(in_high_index);
    hic32  = (hi32 >= n32) ? (n32 - 32'd1) : hi32;
    set_ok = lo32 < n32;
    qry_ok = (lo32 <= hi32) && (lo32 < n32);
    leaf   = AW'(MAX_ELEMENTS) + AW'(lo32);
    parent = node_r >> 1;
    acc_add = acc_r + (pend_r ? ram_rd_data : '0);

    state_nxt     = state_r;
    clr_nxt       = clr_r;
    node_nxt      = node_r;
    cur_nxt       = cur_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    acc_nxt       = acc_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = 1'b0;
    out_sum_nxt   = out_sum_r;
    l1            = l_r;
    r1            = r_r;

    ram_wr_en   = 1'b0;
    ram_wr_addr = '0;
    ram_wr_data = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;

    unique case (state_r)
      ST_CLR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_r;
        clr_nxt     = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (in_mode == MODE_SET) begin
            if (set_ok) begin
              ram_wr_en   = 1'b1;
              ram_wr_addr = leaf;
              ram_wr_data = $unsigned(in_new_value);
              ram_rd_en   = 1'b1;
              ram_rd_addr = leaf ^ AW'(1);
              node_nxt    = leaf;
              cur_nxt     = $unsigned(in_new_value);
              state_nxt   = ST_UPD;
            end
          end else begin
            acc_nxt   = '0;
            state_nxt = ST_QRY;
            if (qry_ok) begin
              l_nxt = RW'(MAX_ELEMENTS) + RW'(lo32);
              r_nxt = RW'(MAX_ELEMENTS) + RW'(hic32) + RW'(1);
            end else begin
              l_nxt = '0;
              r_nxt = '0;
            end
          end
        end
      end
      ST_UPD: begin
        // sibling of node_r is on the read port; write the parent
        ram_wr_en   = 1'b1;
        ram_wr_addr = parent;
        ram_wr_data = cur_r + ram_rd_data;
        cur_nxt     = cur_r + ram_rd_data;
        node_nxt    = parent;
        if (parent == AW'(1)) begin
          state_nxt = ST_IDLE;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = parent ^ AW'(1);
        end
      end
      ST_QRY: begin
        acc_nxt = acc_add;
        if (l_r < r_r) begin
          priority if (l_r[0]) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = l_r[AW-1:0];
            pend_nxt    = 1'b1;
            l1          = l_r + RW'(1);
          end else if (r_r[0]) begin
            r1          = r_r - RW'(1);
            ram_rd_en   = 1'b1;
            ram_rd_addr = r1[AW-1:0];
            pend_nxt    = 1'b1;
          end else begin
            pend_nxt    = 1'b0;
          end
          if (!l1[0] && !r1[0]) begin
            l_nxt = l1 >> 1;
            r_nxt = r1 >> 1;
          end else begin
            l_nxt = l1;
            r_nxt = r1;
          end
        end else begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = acc_add;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      len_r       <= LENGTH_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        len_r <= cfg_wr_data;
      end
    end
    node_r    <= node_nxt;
    cur_r     <= cur_nxt;
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    acc_r     <= acc_nxt;
    out_sum_r <= out_sum_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_range_sum = $signed(out_sum_r);

endmodule

>>> rtl/stsr_chk.sv
// ---------------------------------------------------------------------------
// stsr_chk
// Port-level checks of the range sum core, bound into the core module.
// ---------------------------------------------------------------------------
`include "segment_tree_range_sum_core_defines.svh"

module stsr_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_mode,
  input logic out_valid
);

  import stsr_pkg::*;

  // tree clear runs right after reset
  `STSR_ASSERT_RST(a_clear_after_reset, !rst_n |=> busy, "no clearing pass after reset")
  // result beat lands as the core goes idle
  `STSR_ASSERT(a_result_when_idle, out_valid |-> !busy, "result beat while busy")
  `STSR_ASSERT(a_single_beat, out_valid |=> !out_valid, "result beat repeated")
  `STSR_ASSERT(a_set_no_result, (start && !busy && in_mode == MODE_SET) |=> !out_valid, "set produced a result beat")
  `STSR_ASSERT(a_query_busy, (start && !busy && in_mode == MODE_QUERY) |=> (busy && !out_valid), "query not in progress")

endmodule

bind segment_tree_range_sum_core stsr_chk u_stsr_chk (.*);

>>> bench/range_sum_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// range_sum_checker
// Watches the item, result and cfg ports of the segment tree core, keeps a
// flat mirror of the stored elements and the array length, works out the sum
// owed for every accepted query and compares each result strobe against the
// oldest sum still owed.
// ---------------------------------------------------------------------------
module range_sum_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic                                 in_mode,
  input  logic        [stsr_pkg::INDEX_W-1:0]  in_low_index,
  input  logic        [stsr_pkg::INDEX_W-1:0]  in_high_index,
  input  logic signed [stsr_pkg::VALUE_W-1:0]  in_new_value,
  input  logic                                 out_valid,
  input  logic signed [stsr_pkg::VALUE_W-1:0]  out_range_sum,
  input  logic                                 cfg_wr_en,
  input  logic        [stsr_pkg::LENGTH_W-1:0] cfg_wr_data,
  output int                                   mismatch_count,
  output int                                   sums_owed
);
  import stsr_pkg::*;

  localparam int unsigned ELEMS = MAX_ELEMENTS_DEF;

  logic [VALUE_W-1:0]  elem_mirror [ELEMS];
  logic [LENGTH_W-1:0] length_reg;
  logic [VALUE_W-1:0]  pending_sums [$];

  // wrapped sum of lo..hi, high end clipped to the array in use
  function automatic logic [VALUE_W-1:0] window_total(input int unsigned lo,
                                                     input int unsigned hi,
                                                     input int unsigned n);
    logic [VALUE_W-1:0] acc;
    int unsigned        last;
    int unsigned        i;
    acc = '0;
    last = hi;
    if (lo <= hi && lo < n) begin
      if (last >= n) last = n - 1;
      for (i = lo; i <= last; i++) acc = acc + elem_mirror[i];
    end
    return acc;
  endfunction

  task automatic note_mismatch(input string what, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%t range_sum %s: expected %0d, got %0d", $realtime, what,
               $signed(want), $signed(got));
  endtask

  always @(posedge clk) begin : watch
    logic [VALUE_W-1:0] want;
    int unsigned        n;
    if (!rst_n) begin
      foreach (elem_mirror[i]) elem_mirror[i] = '0;
      length_reg = LENGTH_RESET;
      pending_sums.delete();
      sums_owed = 0;
    end else begin
      n = (length_reg > ELEMS) ? ELEMS : length_reg;
      if (out_valid) begin
        if (pending_sums.size() == 0) begin
          note_mismatch("beat with nothing owed", '0, out_range_sum);
        end else begin
          want = pending_sums.pop_front();
          if (out_range_sum !== want) note_mismatch("mismatch", want, out_range_sum);
        end
      end
      if (cfg_wr_en) length_reg = cfg_wr_data;
      if (start && !busy) begin
        if (in_mode == MODE_SET) begin
          if (in_low_index < n) elem_mirror[in_low_index] = in_new_value;
        end else begin
          pending_sums.push_back(window_total(in_low_index, in_high_index, n));
        end
      end
      sums_owed = pending_sums.size();
    end
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the segment tree range sum core: a directed pass
// over field extremes, reversed and clipped ranges and length changes, then
// random set and query beats over several array lengths with bursty gaps.
// Checking is done by range_sum_checker alongside the core.
// ---------------------------------------------------------------------------
module tb;
  import stsr_pkg::*;

  localparam int RUN_LIMIT    = 600000;
  localparam int SETTLE_CYCLES = 30;
  localparam int DRAIN_CYCLES  = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_mode;
  logic [INDEX_W-1:0]    in_low_index;
  logic [INDEX_W-1:0]    in_high_index;
  logic [VALUE_W-1:0]    in_new_value;
  logic                  out_valid;
  logic [VALUE_W-1:0]    out_range_sum;
  logic                  cfg_wr_en;
  logic [LENGTH_W-1:0]   cfg_wr_data;

  int                    mismatch_count;
  int                    sums_owed;
  int                    cycle_count = 0;
  int unsigned           cur_len;

  segment_tree_range_sum_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_low_index  (in_low_index),
    .in_high_index (in_high_index),
    .in_new_value  (in_new_value),
    .out_valid     (out_valid),
    .out_range_sum (out_range_sum),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  range_sum_checker watcher (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_low_index   (in_low_index),
    .in_high_index  (in_high_index),
    .in_new_value   (in_new_value),
    .out_valid      (out_valid),
    .out_range_sum  (out_range_sum),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatch_count (mismatch_count),
    .sums_owed      (sums_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int unsigned eff_len();
    return (cur_len > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : cur_len;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic issue(input logic m, input logic [INDEX_W-1:0] lo,
                       input logic [INDEX_W-1:0] hi, input logic [VALUE_W-1:0] v);
    start         <= 1'b1;
    in_mode       <= m;
    in_low_index  <= lo;
    in_high_index <= hi;
    in_new_value  <= v;
    while (busy) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
  endtask

  task automatic hold_gap(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (sums_owed != 0);
  endtask

  task automatic set_length(input logic [LENGTH_W-1:0] len);
    start <= 1'b0;
    do @(negedge clk); while (sums_owed != 0 || busy);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_len = len;
  endtask

  function automatic logic [INDEX_W-1:0] pick_index();
    int unsigned n;
    n = eff_len();
    if (n == 0 || $urandom_range(0, 3) == 0) return INDEX_W'($urandom_range(0, 1023));
    if ($urandom_range(0, 7) == 0) return INDEX_W'(n - 1);
    return INDEX_W'($urandom_range(0, n - 1));
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic directed_checks();
    issue(MODE_SET,   10'd0,    10'd0,    32'h7FFF_FFFF);
    issue(MODE_SET,   10'd1023, 10'd0,    32'h8000_0000);
    issue(MODE_SET,   10'd1,    10'd1023, 32'hFFFF_FFFF);
    issue(MODE_SET,   10'd512,  10'd0,    32'h0000_0001);
    issue(MODE_QUERY, 10'd0,    10'd1023, $urandom());
    issue(MODE_QUERY, 10'd0,    10'd1,    32'hFFFF_FFFF);
    issue(MODE_QUERY, 10'd1023, 10'd1023, 32'h0000_0000);
    issue(MODE_QUERY, 10'd0,    10'd0,    $urandom());
    issue(MODE_QUERY, 10'd9,    10'd4,    $urandom());
    issue(MODE_QUERY, 10'd1,    10'd512,  $urandom());
    issue(MODE_SET,   10'd2,    10'd1023, 32'h0000_0000);
    issue(MODE_QUERY, 10'd511,  10'd513,  $urandom());
    // shorter array: set past the end dropped, queries clipped
    set_length(11'd600);
    issue(MODE_SET,   10'd700,  10'd0,    32'h0000_0005);
    issue(MODE_QUERY, 10'd0,    10'd1023, $urandom());
    issue(MODE_QUERY, 10'd700,  10'd900,  $urandom());
    issue(MODE_QUERY, 10'd599,  10'd700,  $urandom());
    issue(MODE_QUERY, 10'd600,  10'd600,  $urandom());
    // empty array
    set_length(11'd0);
    issue(MODE_SET,   10'd0,    10'd0,    32'h0000_007B);
    issue(MODE_QUERY, 10'd0,    10'd1023, $urandom());
    // hidden elements come back
    set_length(11'd1024);
    issue(MODE_QUERY, 10'd0,    10'd1023, $urandom());
    issue(MODE_QUERY, 10'd1023, 10'd1023, $urandom());
  endtask

  task automatic random_phase(input int unsigned target, input bit calm);
    int unsigned        done_cnt;
    int unsigned        stall_at;
    bit                 stalled;
    bit                 no_gaps;
    logic               m;
    logic [INDEX_W-1:0] lo;
    logic [INDEX_W-1:0] hi;
    logic [INDEX_W-1:0] tmp;
    done_cnt = 0;
    stalled  = 1'b0;
    no_gaps  = 1'b0;
    stall_at = $urandom_range(10, target - 1);
    while (done_cnt < target) begin
      m  = ($urandom_range(0, 99) < 45) ? MODE_QUERY : MODE_SET;
      lo = pick_index();
      hi = (m == MODE_QUERY) ? pick_index() : INDEX_W'($urandom_range(0, 1023));
      if (m == MODE_QUERY && lo > hi && $urandom_range(0, 3) != 0) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      if (!calm) begin
        if ($urandom_range(0, 49) == 0) no_gaps = !no_gaps;
        if (!no_gaps && $urandom_range(0, 3) == 0) hold_gap($urandom_range(1, 14));
      end
      if (!calm && !stalled && done_cnt >= stall_at) begin
        stalled = 1'b1;
        drain();
      end
      issue(m, lo, hi, pick_value());
      done_cnt++;
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_mode       = MODE_SET;
    in_low_index  = '0;
    in_high_index = '0;
    in_new_value  = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = LENGTH_RESET;
    cur_len       = LENGTH_RESET;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_checks();

    set_length(11'd2047);
    random_phase(300, 1'b0);
    set_length(11'd1);
    random_phase(150, 1'b0);
    set_length(11'd2);
    random_phase(150, 1'b0);
    set_length(11'd0);
    random_phase(100, 1'b0);
    set_length(11'd1023);
    random_phase(400, 1'b0);
    set_length(LENGTH_W'($urandom_range(3, 1022)));
    random_phase(400, 1'b0);
    set_length(11'd1024);
    random_phase(350, 1'b1);

    start <= 1'b0;
    do @(negedge clk); while (sums_owed != 0 || busy);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
